// ----- hdl/chunk_descriptor_free_list_pool_unit_defines.svh -----
// Assertion macros for the descriptor pool unit.
// Needs a clk and an arst_n in the scope of use.
`ifndef CHUNK_DESCRIPTOR_FREE_LIST_POOL_UNIT_DEFINES_SVH
`define CHUNK_DESCRIPTOR_FREE_LIST_POOL_UNIT_DEFINES_SVH

// same-cycle implication
`define CDFL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("descriptor pool assertion failed");

// next-cycle implication
`define CDFL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("descriptor pool assertion failed");

`endif

// ----- hdl/cdfl_pkg.sv -----
// Package for the descriptor pool: codes, record and control types.
// No dependencies.
package cdfl_pkg;

	localparam int DEF_CAPACITY = 32;

	localparam logic [2:0] CMD_ACQUIRE = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_CLEAR   = 3'd2;
	localparam logic [2:0] CMD_READ    = 3'd3;
	localparam logic [2:0] CMD_SET     = 3'd4;

	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_ZERO_XFER  = 3'd1;
	localparam logic [2:0] STS_NO_DATA    = 3'd2;
	localparam logic [2:0] STS_NO_LEASE   = 3'd3;
	localparam logic [2:0] STS_EXHAUSTED  = 3'd4;
	localparam logic [2:0] STS_NOT_ACTIVE = 3'd5;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [63:0] xfer_id;
		logic [63:0] chunk_off;
		logic [31:0] sequence_num;
		logic [7:0]  flags;
		logic [63:0] payload_address;
		logic [31:0] payload_length;
		logic [63:0] lease_token;
		logic [63:0] owner_val;
	} rec_t;

	// controller -> datapath
	typedef struct packed {
		logic take;        // latch request word, issue memory read
		logic exec;        // apply latched command, load response
		logic sweep;       // clear one entry
		logic sweep_init;  // restart sweep at entry 0
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_clear;    // incoming word is a clear-all
		logic sweep_last;  // sweep sits on the last entry
		logic out_free;    // response register can load
	} dp_sts_t;

endpackage

// ----- hdl/cdfl_if.sv -----
// Request and response channel interfaces for the descriptor pool.
// No dependencies.
interface cdfl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [4:0]  desc_idx;
	logic [63:0] xfer_id;
	logic [63:0] chunk_off;
	logic [31:0] sequence_req;
	logic [7:0]  frame_flags;
	logic [63:0] payload_address;
	logic [31:0] payload_length;
	logic [63:0] lease_token;
	logic        lease_valid;
	logic [63:0] owner_val;

	modport source (output valid, command, desc_idx, xfer_id, chunk_off,
		sequence_req, frame_flags, payload_address, payload_length, lease_token,
		lease_valid, owner_val, input ready);
	modport sink (input valid, command, desc_idx, xfer_id, chunk_off,
		sequence_req, frame_flags, payload_address, payload_length, lease_token,
		lease_valid, owner_val, output ready);
endinterface

interface cdfl_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  result_index;
	logic [63:0] out_transfer_id;
	logic [63:0] out_chunk_offset;
	logic [31:0] out_sequence;
	logic [7:0]  out_flags;
	logic [63:0] out_payload_address;
	logic [31:0] out_payload_length;
	logic [63:0] out_lease_token;
	logic [63:0] out_user_value;
	logic [5:0]  active_count;

	modport source (output valid, status, result_index, out_transfer_id, out_chunk_offset,
		out_sequence, out_flags, out_payload_address, out_payload_length, out_lease_token,
		out_user_value, active_count, input ready);
	modport sink (input valid, status, result_index, out_transfer_id, out_chunk_offset,
		out_sequence, out_flags, out_payload_address, out_payload_length, out_lease_token,
		out_user_value, active_count, output ready);
endinterface

// ----- hdl/chunk_descriptor_free_list_pool_unit.sv -----
// Top level of the chunk descriptor pool with linked free list.
// Depends on cdfl_pkg, cdfl_if, cdfl_ctrl, cdfl_dpath and the defines header.
//
//  channel | dir | handshake        | word
//  req     | in  | valid/ready      | command, index and chunk fields
//  rsp     | out | valid/ready      | status, index, descriptor fields, count
//  cfg     | in  | cfg_we           | capacity_in_use (6 bits)
//
// Each word has a read step (record and link memories), then an execute
// step that checks and writes back; the response register lets the next
// word enter while a response waits. Clear-all, reset and any cfg write
// run a sweep over all CAPACITY entries of both memories (relink, zero fields)
// with req.ready low. A stalled response holds the execute step.
`include "chunk_descriptor_free_list_pool_unit_defines.svh"

module chunk_descriptor_free_list_pool_unit #(
	parameter int CAPACITY = cdfl_pkg::DEF_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	cdfl_req_if.sink   req,
	cdfl_rsp_if.source rsp
);
	import cdfl_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;
	logic    ready;

	// sequencer: owns req.ready and the phase of each word
	cdfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.cfg_we    (cfg_we),
		.sts       (dsts),
		.cmd       (dcmd),
		.req_ready (ready)
	);

	assign req.ready = ready;

	// memories, free-list head, count and response register
	cdfl_dpath #(.CAPACITY(CAPACITY)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (dcmd),
		.sts       (dsts),
		.req       (req),
		.rsp       (rsp)
	);

	// one word in flight at a time
	`CDFL_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
	// cfg write starts a sweep, so no word enters next cycle
	`CDFL_ASSERT_NEXT(a_cfg_sweeps, cfg_we, !req.ready)
	// errors carry no descriptor contents
	`CDFL_ASSERT_NOW(a_err_zero, rsp.valid && rsp.status != STS_OK,
		rsp.out_transfer_id == 64'd0 && rsp.out_lease_token == 64'd0)
endmodule

// ----- hdl/cdfl_ctrl.sv -----
// Sequencer of the descriptor pool: sweep, idle, execute.
// Depends on cdfl_pkg.
module cdfl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              cfg_we,
	input  cdfl_pkg::dp_sts_t sts,
	output cdfl_pkg::dp_cmd_t cmd,
	output logic              req_ready
);
	import cdfl_pkg::*;

	state_t state_q, state_d;
	logic   reply_q, reply_d;
	logic   take;

	assign take = (state_q == S_IDLE) && req_valid;

	always_comb begin
		state_d = state_q;
		reply_d = reply_q;
		if (cfg_we) begin
			state_d = S_CLEAR;
			reply_d = 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.sweep_last) state_d = reply_q ? S_EXEC : S_IDLE;
				end
				S_IDLE: begin
					if (take) begin
						state_d = sts.is_clear ? S_CLEAR : S_EXEC;
						reply_d = sts.is_clear;
					end
				end
				S_EXEC: begin
					if (sts.out_free) begin
						state_d = S_IDLE;
						reply_d = 1'b0;
					end
				end
				default: state_d = S_CLEAR;
			endcase
		end
	end

	always_comb begin
		req_ready      = (state_q == S_IDLE) && !cfg_we;
		cmd.take       = take && !cfg_we;
		cmd.exec       = (state_q == S_EXEC) && sts.out_free && !cfg_we;
		cmd.sweep      = (state_q == S_CLEAR) && !cfg_we;
		cmd.sweep_init = cfg_we || (take && sts.is_clear);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			reply_q <= reply_d;
		end
	end
endmodule

// ----- hdl/cdfl_dpath.sv -----
// Datapath of the descriptor pool: record and link memories, head, count,
// request latch and response register. Depends on cdfl_pkg and cdfl_if.
module cdfl_dpath #(
	parameter int CAPACITY = cdfl_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	input  cdfl_pkg::dp_cmd_t cmd,
	output cdfl_pkg::dp_sts_t sts,
	cdfl_req_if.sink          req,
	cdfl_rsp_if.source        rsp
);
	import cdfl_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	rec_t          rec_mem [CAPACITY];
	logic [CW-1:0] link_mem [CAPACITY];

	rec_t          rd_rec_q;
	logic [CW-1:0] rd_link_q;

	logic [5:0]    capacity_q;
	logic [CW-1:0] head_q, count_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] cap;

	// latched request
	logic [2:0]    cmd_q;
	logic [4:0]    idx_q;
	rec_t          new_q;
	logic          lease_ok_q;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [4:0]    out_index_q;
	rec_t          out_rec_q;
	logic [5:0]    out_count_q;

	// execute-stage results
	logic          rec_we, link_we;
	logic [AW-1:0] waddr;
	rec_t          rec_wdata;
	logic [CW-1:0] link_wdata;
	logic [CW-1:0] head_d, count_d;
	logic [2:0]    status_d;
	logic [4:0]    index_d;
	rec_t          rec_out_d;
	logic          idx_bad;
	logic [CW-1:0] sweep_nxt;
	logic [AW-1:0] raddr;

	always_comb begin
		if (capacity_q == 6'd0 || 32'(capacity_q) > 32'(CAPACITY)) cap = CW'(CAPACITY);
		else cap = CW'(capacity_q);
	end

	assign sts.is_clear   = (req.command == CMD_CLEAR);
	assign sts.sweep_last = (ptr_q == AW'(CAPACITY - 1));
	assign sts.out_free   = !out_valid_q || rsp.ready;

	assign raddr     = (req.command == CMD_ACQUIRE) ? AW'(head_q) : AW'(req.desc_idx);
	assign sweep_nxt = ((CW'(ptr_q) + CW'(1)) < cap) ? (CW'(ptr_q) + CW'(1)) : cap;
	assign idx_bad   = 32'(idx_q) >= 32'(cap);

	always_comb begin
		rec_we     = 1'b0;
		link_we    = 1'b0;
		waddr      = AW'(idx_q);
		rec_wdata  = '0;
		link_wdata = head_q;
		head_d     = head_q;
		count_d    = count_q;
		status_d   = STS_OK;
		index_d    = '0;
		rec_out_d  = '0;
		if (cmd.sweep) begin
			rec_we     = 1'b1;
			link_we    = 1'b1;
			waddr      = ptr_q;
			link_wdata = sweep_nxt;
		end else if (cmd.exec) begin
			unique case (cmd_q)
				CMD_ACQUIRE: begin
					if (new_q.xfer_id == 64'd0) status_d = STS_ZERO_XFER;
					else if (new_q.payload_length != 32'd0 && new_q.payload_address == 64'd0)
						status_d = STS_NO_DATA;
					else if (new_q.payload_length != 32'd0 && !lease_ok_q)
						status_d = STS_NO_LEASE;
					else if (count_q >= cap || 32'(head_q) >= 32'(CAPACITY))
						status_d = STS_EXHAUSTED;
					else begin
						rec_we     = 1'b1;
						link_we    = 1'b1;
						waddr      = AW'(head_q);
						rec_wdata  = new_q;
						link_wdata = cap;
						head_d     = rd_link_q;
						count_d    = count_q + CW'(1);
						index_d    = 5'(head_q);
						rec_out_d  = new_q;
					end
				end
				CMD_RELEASE: begin
					index_d = idx_q;
					if (idx_bad || rd_rec_q.xfer_id == 64'd0 || count_q == '0)
						status_d = STS_NOT_ACTIVE;
					else begin
						rec_we     = 1'b1;
						link_we    = 1'b1;
						link_wdata = head_q;
						head_d     = CW'(idx_q);
						count_d    = count_q - CW'(1);
						rec_out_d  = rd_rec_q;
					end
				end
				CMD_READ: begin
					index_d = idx_q;
					if (idx_bad) status_d = STS_NOT_ACTIVE;
					else rec_out_d = rd_rec_q;
				end
				CMD_SET: begin
					index_d = idx_q;
					if (idx_bad || rd_rec_q.xfer_id == 64'd0) status_d = STS_NOT_ACTIVE;
					else begin
						rec_we              = 1'b1;
						rec_wdata           = rd_rec_q;
						rec_wdata.owner_val = new_q.owner_val;
						rec_out_d           = rec_wdata;
					end
				end
				default: ;
			endcase
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (rec_we) rec_mem[waddr] <= rec_wdata;
		if (link_we) link_mem[waddr] <= link_wdata;
		if (cmd.take) begin
			rd_rec_q  <= rec_mem[raddr];
			rd_link_q <= link_mem[raddr];
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q                   <= req.command;
			idx_q                   <= req.desc_idx;
			new_q.xfer_id           <= req.xfer_id;
			new_q.chunk_off         <= req.chunk_off;
			new_q.sequence_num      <= req.sequence_req;
			new_q.flags             <= req.frame_flags;
			new_q.payload_address   <= req.payload_address;
			new_q.payload_length    <= req.payload_length;
			new_q.lease_token       <= (req.payload_length != 32'd0) ? req.lease_token : 64'd0;
			new_q.owner_val         <= req.owner_val;
			lease_ok_q              <= req.lease_valid;
		end
		if (cmd.exec) begin
			out_status_q <= status_d;
			out_index_q  <= index_d;
			out_rec_q    <= rec_out_d;
			out_count_q  <= 6'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= '0;
			head_q      <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) capacity_q <= cfg_wdata;
			if (cmd.sweep_init) begin
				ptr_q   <= '0;
				head_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.sweep) ptr_q <= ptr_q + AW'(1);
				head_q  <= head_d;
				count_q <= count_d;
			end
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid               = out_valid_q;
	assign rsp.status              = out_status_q;
	assign rsp.result_index        = out_index_q;
	assign rsp.out_transfer_id     = out_rec_q.xfer_id;
	assign rsp.out_chunk_offset    = out_rec_q.chunk_off;
	assign rsp.out_sequence        = out_rec_q.sequence_num;
	assign rsp.out_flags           = out_rec_q.flags;
	assign rsp.out_payload_address = out_rec_q.payload_address;
	assign rsp.out_payload_length  = out_rec_q.payload_length;
	assign rsp.out_lease_token     = out_rec_q.lease_token;
	assign rsp.out_user_value      = out_rec_q.owner_val;
	assign rsp.active_count        = out_count_q;
endmodule
